// ===== rtl/fmod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmod_pkg
// Shared types and constants of the floating-point remainder unit.
// ----------------------------------------------------------------------------
package fmod_pkg;

   localparam int SIG_W = 53;     // significand with hidden bit, binary64
   localparam int EXP_W = 13;     // signed working exponent

   localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] QNAN32 = 64'h0000_0000_7FC0_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_DIV,
      ST_POST,
      ST_DONE
   } state_type;

   // Datapath step commands from the sequencer.
   typedef struct packed {
      logic load;
      logic norm;
      logic div;
      logic post;
   } ctl_type;

   typedef struct packed {
      logic x_norm_done;
      logic y_norm_done;
      logic div_last;
      logic rem_zero;
      logic post_done;
      logic early;
   } sts_type;

endpackage

// ===== rtl/fmod_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmod_ctrl
// Sequencer: normalize, shift-subtract, renormalize, deliver.
// ----------------------------------------------------------------------------
module fmod_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  fmod_pkg::sts_type  sts,
   output fmod_pkg::ctl_type  ctl,
   output logic               busy,
   output logic               done
);

   fmod_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmod_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fmod_pkg::ST_IDLE: begin
            if (start) state_in = fmod_pkg::ST_NORM;
         end
         fmod_pkg::ST_NORM: begin
            if (sts.early) state_in = fmod_pkg::ST_DONE;
            else if (sts.x_norm_done && sts.y_norm_done) state_in = fmod_pkg::ST_DIV;
         end
         fmod_pkg::ST_DIV: begin
            // Small dividend is flagged on the last normalize cycle
            if (sts.early) state_in = fmod_pkg::ST_DONE;
            else if (sts.div_last || sts.rem_zero) state_in = fmod_pkg::ST_POST;
         end
         fmod_pkg::ST_POST: begin
            if (sts.post_done) state_in = fmod_pkg::ST_DONE;
         end
         fmod_pkg::ST_DONE: state_in = fmod_pkg::ST_IDLE;
         default: state_in = fmod_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.load = (state_ff == fmod_pkg::ST_IDLE) && start;
      ctl.norm = (state_ff == fmod_pkg::ST_NORM);
      ctl.div  = (state_ff == fmod_pkg::ST_DIV);
      ctl.post = (state_ff == fmod_pkg::ST_POST);
   end

   assign busy = (state_ff != fmod_pkg::ST_IDLE);
   assign done = (state_ff == fmod_pkg::ST_DONE);

endmodule

// ===== rtl/fmod_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmod_dpath
// Operand unpack, one subtract/shift step per cycle, result packing.
// ----------------------------------------------------------------------------
module fmod_dpath (
   input  logic               clock,
   input  fmod_pkg::ctl_type  ctl,
   input  logic               mode,
   input  logic [63:0]        dividend_bits,
   input  logic [63:0]        divisor_bits,
   output fmod_pkg::sts_type  sts,
   output logic [63:0]        remainder_bits,
   output logic               invalid_flag
);

   localparam int SW = fmod_pkg::SIG_W;
   localparam int EW = fmod_pkg::EXP_W;

   logic              dbl_ff;
   logic [63:0]       xb_ff;
   logic              sx_ff;
   logic [SW-1:0]     mx_ff, my_ff, mx_in, my_in;
   logic signed [EW-1:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [SW:0]       r_ff, r_in;
   logic [63:0]       res_ff, res_in;
   logic              inv_ff, inv_in, early_ff, early_in;

   // Unpack of the request
   logic [63:0] xa, ya;
   logic [10:0] exr, eyr;
   logic [51:0] mxr, myr;
   logic        xmax, ymax, xz, yz;
   logic [5:0]  top;

   always_comb begin
      if (mode) begin
         xa = dividend_bits;
         ya = divisor_bits;
         exr = xa[62:52]; eyr = ya[62:52];
         mxr = xa[51:0];  myr = ya[51:0];
         xmax = &exr; ymax = &eyr;
      end else begin
         xa = {32'd0, dividend_bits[31:0]};
         ya = {32'd0, divisor_bits[31:0]};
         exr = {3'd0, xa[30:23]}; eyr = {3'd0, ya[30:23]};
         mxr = {xa[22:0], 29'd0}; myr = {ya[22:0], 29'd0};
         xmax = &xa[30:23]; ymax = &ya[30:23];
      end
      xz = (exr == 11'd0);
      yz = (eyr == 11'd0);
      top = dbl_ff ? 6'd63 : 6'd31;
   end

   logic [SW:0] diff;
   logic        ge;
   logic [SW-1:0] rn;
   logic signed [EW-1:0] e_sub;
   logic [5:0]  sh;
   logic [SW-1:0] frac_sh;

   always_comb begin
      mx_in = mx_ff; my_in = my_ff; ex_in = ex_ff; ey_in = ey_ff;
      r_in = r_ff; res_in = res_ff; inv_in = inv_ff; early_in = early_ff;
      diff = r_ff - {1'b0, my_ff};
      ge = (r_ff >= {1'b0, my_ff});
      rn = ge ? diff[SW-1:0] : r_ff[SW-1:0];
      e_sub = '0; sh = '0; frac_sh = '0;
      if (ctl.load) begin
         inv_in = 1'b0; early_in = 1'b0;
         mx_in = {~xz, mxr}; my_in = {~yz, myr};
         ex_in = xz ? EW'(1) : EW'(exr);
         ey_in = yz ? EW'(1) : EW'(eyr);
         if (xmax || (ymax && myr != 52'd0) || (yz && myr == 52'd0)) begin
            res_in = mode ? fmod_pkg::QNAN64 : fmod_pkg::QNAN32;
            inv_in = 1'b1; early_in = 1'b1;
         end else if (ymax || (xz && mxr == 52'd0)) begin
            res_in = xa; early_in = 1'b1;
         end
      end else if (ctl.norm && !early_ff) begin
         if (!mx_ff[SW-1]) begin mx_in = mx_ff << 1; ex_in = ex_ff - EW'(1); end
         if (!my_ff[SW-1]) begin my_in = my_ff << 1; ey_in = ey_ff - EW'(1); end
         if (mx_ff[SW-1] && my_ff[SW-1]) begin
            r_in = {1'b0, mx_ff};
            if (ex_ff < ey_ff || (ex_ff == ey_ff && mx_ff < my_ff)) begin
               res_in = xb_ff; early_in = 1'b1;
            end
         end
      end else if (ctl.div) begin
         if (ex_ff > ey_ff) begin
            r_in = {rn, 1'b0};
            ex_in = ex_ff - EW'(1);
         end else begin
            r_in = {1'b0, rn};
         end
         if (rn == '0) r_in = '0;
         ex_in = (ex_ff > ey_ff) ? ex_ff - EW'(1) : ey_ff;
      end else if (ctl.post) begin
         if (r_ff == '0) begin
            res_in = '0;
            res_in[top] = sx_ff;
         end else if (!r_ff[SW-1]) begin
            r_in = r_ff << 1; ex_in = ex_ff - EW'(1);
         end else begin
            if (ex_ff >= EW'(1)) begin
               e_sub = ex_ff;
               frac_sh = r_ff[SW-1:0];
            end else begin
               e_sub = '0;
               sh = 6'(EW'(1) - ex_ff);
               frac_sh = (EW'(1) - ex_ff >= EW'(SW)) ? '0 : (r_ff[SW-1:0] >> sh);
            end
            if (dbl_ff) begin
               res_in = {sx_ff, e_sub[10:0], frac_sh[51:0]};
            end else begin
               res_in = {32'd0, sx_ff, e_sub[7:0], frac_sh[51:29]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in; my_ff <= my_in; ex_ff <= ex_in; ey_ff <= ey_in;
      r_ff <= r_in; res_ff <= res_in; inv_ff <= inv_in; early_ff <= early_in;
      if (ctl.load) begin
         dbl_ff <= mode;
         xb_ff <= xa;
         sx_ff <= mode ? xa[63] : xa[31];
      end
   end

   assign sts.x_norm_done = mx_ff[SW-1];
   assign sts.y_norm_done = my_ff[SW-1];
   assign sts.early       = early_ff;
   assign sts.div_last    = !(ex_ff > ey_ff);
   assign sts.rem_zero    = (r_ff == '0);
   assign sts.post_done   = (r_ff == '0) || r_ff[SW-1];

   assign remainder_bits = res_ff;
   assign invalid_flag   = inv_ff;

endmodule

// ===== rtl/float_remainder_fmod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_remainder_fmod_unit
// C fmod of two binary32/binary64 bit patterns, exact shift-and-subtract.
// ----------------------------------------------------------------------------
//  channel  | ports                                              | handshake
//  request  | req_mode, req_dividend_bits, req_divisor_bits      | start & !busy
//  result   | rsp_remainder_bits, rsp_invalid_flag               | done, one cycle
//
//  Per request: special operands go straight to the result; otherwise the
//  significands are normalized, one shift-subtract step runs per unit of
//  exponent difference plus one, and the remainder is renormalized for the result.
//  The shift-subtract loop over the exponent difference sets the latency.
//  Reset returns the sequencer to idle. The receiver cannot stall.
// ----------------------------------------------------------------------------
module float_remainder_fmod_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [63:0] req_dividend_bits,
   input  logic [63:0] req_divisor_bits,
   output logic        done,
   output logic [63:0] rsp_remainder_bits,
   output logic        rsp_invalid_flag
);

   fmod_pkg::ctl_type ctl;
   fmod_pkg::sts_type sts;

   fmod_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy),
      .done  (done)
   );

   fmod_dpath u_dpath (
      .clock          (clock),
      .ctl            (ctl),
      .mode           (req_mode),
      .dividend_bits  (req_dividend_bits),
      .divisor_bits   (req_divisor_bits),
      .sts            (sts),
      .remainder_bits (rsp_remainder_bits),
      .invalid_flag   (rsp_invalid_flag)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for float_remainder_fmod_unit: directed special operands
// and random binary32/binary64 requests, checked against an exact remainder
// predictor in a scoreboard, with random request gaps.
// ----------------------------------------------------------------------------

class fmod_scoreboard;
   logic [63:0] want_rem[$];
   logic        want_inv[$];
   int          mismatches = 0;

   // Exact truncated remainder on one format; widths passed as ints.
   static function void remainder_of(input logic [63:0] xb, input logic [63:0] yb,
                                     input int ebits, input int mbits,
                                     input logic [63:0] qnan,
                                     output logic [63:0] res, output logic inv);
      logic [63:0] signbit, mmask, mx, my, sx, r;
      int emax, ex, ey, e, sh;
      signbit = 64'd1 << (ebits + mbits);
      mmask = (64'd1 << mbits) - 64'd1;
      emax = (1 << ebits) - 1;
      ex = int'((xb >> mbits) & emax);
      ey = int'((yb >> mbits) & emax);
      mx = xb & mmask;
      my = yb & mmask;
      sx = xb & signbit;
      inv = 1'b0;
      res = xb;
      if (ex == emax || (ey == emax && my != 0) || (ey == 0 && my == 0)) begin
         res = qnan;
         inv = 1'b1;
         return;
      end
      if (ey == emax || (ex == 0 && mx == 0)) return;
      if (ex == 0) begin
         ex = 1;
         while (mx[mbits] == 1'b0) begin mx = mx << 1; ex--; end
      end else mx[mbits] = 1'b1;
      if (ey == 0) begin
         ey = 1;
         while (my[mbits] == 1'b0) begin my = my << 1; ey--; end
      end else my[mbits] = 1'b1;
      if (ex < ey || (ex == ey && mx < my)) return;
      r = mx;
      while (ex > ey) begin
         if (r >= my) r -= my;
         if (r == 0) begin res = sx; return; end
         r = r << 1;
         ex--;
      end
      if (r >= my) r -= my;
      if (r == 0) begin res = sx; return; end
      e = ey;
      while (r[mbits] == 1'b0) begin r = r << 1; e--; end
      if (e >= 1) res = sx | (64'(e) << mbits) | (r & mmask);
      else begin
         sh = 1 - e;
         r = (sh < 64) ? (r >> sh) : 64'd0;
         res = sx | r;
      end
   endfunction

   function void note_request(input logic mode, input logic [63:0] x, input logic [63:0] y);
      logic [63:0] res;
      logic inv;
      if (mode)
         remainder_of(x, y, 11, 52, fmod_pkg::QNAN64, res, inv);
      else begin
         remainder_of({32'd0, x[31:0]}, {32'd0, y[31:0]}, 8, 23, fmod_pkg::QNAN32,
                      res, inv);
         res[63:32] = 32'd0;
      end
      want_rem.push_back(res);
      want_inv.push_back(inv);
   endfunction

   function void check_result(input logic [63:0] rem, input logic inv);
      logic [63:0] er;
      logic ei;
      if (want_rem.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result rem=%h inv=%b", rem, inv);
         return;
      end
      er = want_rem.pop_front();
      ei = want_inv.pop_front();
      if (er !== rem || ei !== inv) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: expected rem=%h inv=%b, got rem=%h inv=%b",
                     er, ei, rem, inv);
      end
   endfunction

   function int pending();
      return want_rem.size();
   endfunction
endclass

module testbench;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_COUNT = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [63:0] req_dividend_bits = 64'd0;
   logic [63:0] req_divisor_bits = 64'd0;
   logic        done;
   logic [63:0] rsp_remainder_bits;
   logic        rsp_invalid_flag;

   fmod_scoreboard fmod_board = new();
   int  quiet_cycles = 0;
   bit  gaps_enabled = 1'b1;

   float_remainder_fmod_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (done) fmod_board.check_result(rsp_remainder_bits, rsp_invalid_flag);
         if ((start && !busy) || done) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic mode, input logic [63:0] x, input logic [63:0] y);
      while (gaps_enabled && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_dividend_bits <= x;
      req_divisor_bits <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      fmod_board.note_request(mode, x, y);
      @(negedge clock);
   endtask

   // Random operand of one format; kind 0 keeps a small exponent spread around the bias.
   function automatic logic [63:0] random_operand(input logic mode, input int kind);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (mode) begin
         case (kind)
            0: v[62:52] = 11'(1023 + $urandom_range(40) - 20);
            1: v[62:52] = 11'($urandom_range(2));
            2: v[62:52] = 11'($urandom_range(2047));
            default: ;
         endcase
      end else begin
         case (kind)
            0: v[30:23] = 8'(127 + $urandom_range(40) - 20);
            1: v[30:23] = 8'($urandom_range(2));
            default: ;
         endcase
      end
      return v;
   endfunction

   initial begin
      logic m;
      int kx, ky;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Special operands in both formats.
      send_request(1, 64'h4014_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_request(1, 64'hC014_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_request(1, 64'h4018_0000_0000_0000, 64'hC008_0000_0000_0000);
      send_request(1, 64'h8018_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_request(1, 64'h4008_0000_0000_0000, 64'h0000_0000_0000_0000);
      send_request(1, 64'h7FF0_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_request(1, 64'h4008_0000_0000_0000, 64'h7FF0_0000_0000_0001);
      send_request(1, 64'hFFF8_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_request(1, 64'hC008_0000_0000_0000, 64'hFFF0_0000_0000_0000);
      send_request(1, 64'h3FF0_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_request(1, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
      send_request(1, 64'h0008_0000_0000_0003, 64'h0000_0000_0000_0002);
      send_request(1, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001);
      send_request(1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(0, 64'hFFFF_FFFF_40A0_0000, 64'hAAAA_AAAA_4040_0000);
      send_request(0, 64'h0000_0000_C0A0_0000, 64'h0000_0000_0000_0000);
      send_request(0, 64'h0000_0000_7F80_0000, 64'h0000_0000_4040_0000);
      send_request(0, 64'h0000_0000_4040_0000, 64'h0000_0000_7FC0_0001);
      send_request(0, 64'h0000_0000_8000_0000, 64'h0000_0000_FF80_0000);
      send_request(0, 64'h0000_0000_7F7F_FFFF, 64'h0000_0000_0000_0001);
      send_request(0, 64'h0000_0000_0040_0003, 64'h0000_0000_0000_0002);
      send_request(0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         gaps_enabled = !(i >= 100 && i < 150);
         m = $urandom_range(1);
         kx = ($urandom_range(9) < 7) ? 0 : $urandom_range(3);
         ky = ($urandom_range(9) < 7) ? 0 : $urandom_range(3);
         // Keep full-range binary64 exponent differences rare.
         if (m && kx == 2 && ky != 2 && $urandom_range(3) != 0) kx = 0;
         send_request(m, random_operand(m, kx), random_operand(m, ky));
      end
      start <= 1'b0;
      while (fmod_board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fmod_board.mismatches == 0 && fmod_board.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
